// ===== sv/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // Edges are cut down to this many magnitude bits before the cross product.
    localparam int EDGE_LIMIT    = 30;
    // Cross product components are pre-scaled below 2^PRESCALE_BITS.
    localparam int PRESCALE_BITS = 30;

    // Default widths for the root and divider stages at the default coordinates.
    localparam int MAG_W_DEF = PRESCALE_BITS + 1;
    localparam int LEN_W_DEF = MAG_W_DEF + 1;

endpackage

// ===== sv/tfn_isqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tfn_isqrt
    import tfn_pkg::*;
#(
    parameter int ROOT_W = LEN_W_DEF,
    parameter int SIDE_W = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_x,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int SW = 2 * ROOT_W;

    // rem = x - root^2 at every stage
    logic [SW-1:0]     rem_reg   [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg  [1:ROOT_W];
    logic [SIDE_W-1:0] side_reg  [1:ROOT_W];
    logic              valid_reg [1:ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        localparam int K = ROOT_W - 1 - i;

        logic [SW-1:0]     src_rem;
        logic [ROOT_W-1:0] src_root;
        logic [SIDE_W-1:0] src_side;
        logic              src_valid;
        logic [SW:0]       trial;
        logic [SW-1:0]     rem_next;
        logic [ROOT_W-1:0] root_next;

        if (i == 0) begin : g_first
            assign src_rem   = in_x;
            assign src_root  = '0;
            assign src_side  = in_side;
            assign src_valid = in_valid;
        end
        else begin : g_mid
            assign src_rem   = rem_reg[i];
            assign src_root  = root_reg[i];
            assign src_side  = side_reg[i];
            assign src_valid = valid_reg[i];
        end

        // try bit K: (root + 2^K)^2 - root^2 = root*2^(K+1) + 4^K
        always_comb
        begin
            trial = ((SW + 1)'(src_root) << (K + 1)) + ((SW + 1)'(1) << (2 * K));
            if ({1'b0, src_rem} >= trial)
            begin
                rem_next  = src_rem - trial[SW-1:0];
                root_next = src_root | (ROOT_W'(1) << K);
            end
            else
            begin
                rem_next  = src_rem;
                root_next = src_root;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
                side_reg[i+1] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

// ===== sv/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined rounded division of three magnitudes by a shared length,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfn_div
    import tfn_pkg::*;
#(
    parameter int MAG_W  = MAG_W_DEF,
    parameter int LEN_W  = LEN_W_DEF,
    parameter int FRAC_W = NORMAL_FRAC_BITS_DEF,
    parameter int SIDE_W = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [MAG_W-1:0]    in_mag  [3],
    input  logic [LEN_W-1:0]    in_len,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [FRAC_W:0]     out_quot [3],
    output logic [SIDE_W-1:0]   out_side
);

    localparam int ST  = FRAC_W + 1;
    localparam int DNW = (MAG_W + FRAC_W + 1 > LEN_W + FRAC_W) ?
                         MAG_W + FRAC_W + 1 : LEN_W + FRAC_W;

    logic [DNW-1:0]    rem_reg   [1:ST][3];
    logic [FRAC_W:0]   quot_reg  [1:ST][3];
    logic [LEN_W-1:0]  len_reg   [1:ST];
    logic [SIDE_W-1:0] side_reg  [1:ST];
    logic              valid_reg [1:ST];

    logic [DNW-1:0]    num [3];

    // numerator |r| * 2^F + floor(L / 2) gives round half away from zero
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            num[c] = (DNW'(in_mag[c]) << FRAC_W) + DNW'(in_len >> 1);
    end

    for (genvar i = 0; i < ST; i++) begin : g_stage
        localparam int J = ST - 1 - i;

        logic [DNW-1:0]    src_rem  [3];
        logic [FRAC_W:0]   src_quot [3];
        logic [LEN_W-1:0]  src_len;
        logic [SIDE_W-1:0] src_side;
        logic              src_valid;
        logic [DNW:0]      shifted;
        logic [DNW-1:0]    rem_next  [3];
        logic [FRAC_W:0]   quot_next [3];

        if (i == 0) begin : g_first
            assign src_rem   = num;
            assign src_quot  = '{default: '0};
            assign src_len   = in_len;
            assign src_side  = in_side;
            assign src_valid = in_valid;
        end
        else begin : g_mid
            assign src_rem   = rem_reg[i];
            assign src_quot  = quot_reg[i];
            assign src_len   = len_reg[i];
            assign src_side  = side_reg[i];
            assign src_valid = valid_reg[i];
        end

        always_comb
        begin
            shifted = (DNW + 1)'(src_len) << J;
            for (int c = 0; c < 3; c++)
            begin
                if ({1'b0, src_rem[c]} >= shifted)
                begin
                    rem_next[c]  = src_rem[c] - shifted[DNW-1:0];
                    quot_next[c] = src_quot[c] | ((FRAC_W + 1)'(1) << J);
                end
                else
                begin
                    rem_next[c]  = src_rem[c];
                    quot_next[c] = src_quot[c];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                quot_reg[i+1] <= quot_next;
                len_reg[i+1]  <= src_len;
                side_reg[i+1] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[ST];
    assign out_quot  = quot_reg[ST];
    assign out_side  = side_reg[ST];

endmodule

// ===== sv/triangle_flat_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_flat_normal
// Unit face normal of a triangle from three fixed-point vertices.
// ----------------------------------------------------------------------------
// Takes one triangle per cycle while tri_stall is low and returns its unit
// normal (B-A) x (C-A) in signed fixed point with NORMAL_FRAC_BITS fraction
// bits, rounded to nearest. A zero cross product returns (0, 1.0, 0) with
// degenerate set. The square root resolves one bit per stage over the root
// width R (32 at the default widths) and the divider one quotient bit per
// stage. The whole pipeline holds while a result waits under nrm_stall.
module triangle_flat_normal
    import tfn_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tri_valid,
    output logic                               tri_stall,
    input  logic signed [COORD_BITS-1:0]       a_x,
    input  logic signed [COORD_BITS-1:0]       a_y,
    input  logic signed [COORD_BITS-1:0]       a_z,
    input  logic signed [COORD_BITS-1:0]       b_x,
    input  logic signed [COORD_BITS-1:0]       b_y,
    input  logic signed [COORD_BITS-1:0]       b_z,
    input  logic signed [COORD_BITS-1:0]       c_x,
    input  logic signed [COORD_BITS-1:0]       c_y,
    input  logic signed [COORD_BITS-1:0]       c_z,
    output logic                               nrm_valid,
    input  logic                               nrm_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0] norm_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] norm_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] norm_z,
    output logic                               degenerate
);

    localparam int DW   = COORD_BITS + 1;
    localparam int EW   = (COORD_BITS > EDGE_LIMIT) ? EDGE_LIMIT + 1 : COORD_BITS + 1;
    localparam int ESH  = (COORD_BITS > EDGE_LIMIT) ? COORD_BITS - EDGE_LIMIT : 0;
    localparam int PW   = 2 * EW;
    localparam int NW   = 2 * EW + 1;
    localparam int MW   = NW - 1;
    localparam int RMW  = (MW > PRESCALE_BITS + 1) ? PRESCALE_BITS + 1 : MW;
    localparam int SW   = 2 * RMW + 2;
    localparam int QW   = RMW + 1;
    localparam int F    = NORMAL_FRAC_BITS;
    localparam int OW   = F + 2;
    localparam int SHW  = $clog2(MW + 1);
    localparam int SQS  = 4 + 3 * RMW;

    logic en;

    logic signed [COORD_BITS-1:0] pa [3];
    logic signed [COORD_BITS-1:0] pb [3];
    logic signed [COORD_BITS-1:0] pc [3];
    logic signed [DW-1:0]         d1 [3];
    logic signed [DW-1:0]         d2 [3];

    // stage 1: edges
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    // stage 2: products
    logic signed [PW-1:0] pp_reg  [6];
    logic signed [PW-1:0] pp_next [6];
    // stage 3: cross product
    logic signed [NW-1:0] n3_reg  [3];
    logic signed [NW-1:0] n3_next [3];
    // stage 4: magnitude OR
    logic signed [NW-1:0] n4_reg [3];
    logic [MW-1:0]        mor_reg;
    logic [MW-1:0]        mor_next;
    logic [NW-1:0]        nmag [3];
    // stage 5: pre-scale shift
    logic signed [NW-1:0] n5_reg [3];
    logic [SHW-1:0]       sh_reg;
    logic [SHW-1:0]       sh_next;
    logic [SHW-1:0]       blen;
    logic                 dg5_reg;
    // stage 6: scaled components
    logic signed [RMW:0]  r6_reg  [3];
    logic signed [RMW:0]  r6_next [3];
    logic                 dg6_reg;
    // stage 7: squares
    logic [RMW-1:0]       rm7_reg  [3];
    logic [RMW-1:0]       rm7_next [3];
    logic [2*RMW-1:0]     sq7_reg  [3];
    logic [2*RMW-1:0]     sq7_next [3];
    logic [2:0]           sg7_reg;
    logic                 dg7_reg;
    // stage 8: sum of squares
    logic [SW-1:0]        sum8_reg;
    logic [RMW-1:0]       rm8_reg [3];
    logic [2:0]           sg8_reg;
    logic                 dg8_reg;

    logic [8:1]           v_reg;

    logic                 sq_valid;
    logic [QW-1:0]        sq_root;
    logic [SQS-1:0]       sq_side_in;
    logic [SQS-1:0]       sq_side;
    logic [RMW-1:0]       dv_mag [3];

    logic                 dv_valid;
    logic [F:0]           dv_quot [3];
    logic [3:0]           dv_side;

    logic                 out_valid_reg;
    logic signed [OW-1:0] nx_reg, ny_reg, nz_reg;
    logic                 dg_reg;
    logic signed [OW-1:0] comp_next [3];

    // advance everything unless the output holds an untaken transaction
    assign en        = !(out_valid_reg && nrm_stall);
    assign tri_stall = !en;

    assign pa = '{a_x, a_y, a_z};
    assign pb = '{b_x, b_y, b_z};
    assign pc = '{c_x, c_y, c_z};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1[i]      = DW'(pb[i]) - DW'(pa[i]);
            d2[i]      = DW'(pc[i]) - DW'(pa[i]);
            e1_next[i] = EW'(d1[i] >>> ESH);
            e2_next[i] = EW'(d2[i] >>> ESH);
        end
    end

    always_comb
    begin
        pp_next[0] = PW'(e1_reg[1]) * PW'(e2_reg[2]);
        pp_next[1] = PW'(e1_reg[2]) * PW'(e2_reg[1]);
        pp_next[2] = PW'(e1_reg[2]) * PW'(e2_reg[0]);
        pp_next[3] = PW'(e1_reg[0]) * PW'(e2_reg[2]);
        pp_next[4] = PW'(e1_reg[0]) * PW'(e2_reg[1]);
        pp_next[5] = PW'(e1_reg[1]) * PW'(e2_reg[0]);
        for (int i = 0; i < 3; i++)
            n3_next[i] = NW'(pp_reg[2*i]) - NW'(pp_reg[2*i+1]);
    end

    // OR of magnitudes has the same bit length as their maximum
    always_comb
    begin
        mor_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            nmag[i]  = n3_reg[i][NW-1] ? NW'(-n3_reg[i]) : NW'(n3_reg[i]);
            mor_next = mor_next | nmag[i][MW-1:0];
        end
    end

    always_comb
    begin
        blen = '0;
        for (int b = 0; b < MW; b++)
            if (mor_reg[b])
                blen = SHW'(b + 1);
        sh_next = (blen > SHW'(PRESCALE_BITS)) ? blen - SHW'(PRESCALE_BITS) : '0;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            r6_next[i] = (RMW + 1)'(n5_reg[i] >>> sh_reg);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rm7_next[i] = r6_reg[i][RMW] ? RMW'(-r6_reg[i]) : RMW'(r6_reg[i]);
            sq7_next[i] = (2 * RMW)'(rm7_next[i]) * (2 * RMW)'(rm7_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[7:1], tri_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            pp_reg   <= pp_next;
            n3_reg   <= n3_next;
            n4_reg   <= n3_reg;
            mor_reg  <= mor_next;
            n5_reg   <= n4_reg;
            sh_reg   <= sh_next;
            dg5_reg  <= (mor_reg == '0);
            r6_reg   <= r6_next;
            dg6_reg  <= dg5_reg;
            rm7_reg  <= rm7_next;
            sq7_reg  <= sq7_next;
            sg7_reg  <= {r6_reg[2][RMW], r6_reg[1][RMW], r6_reg[0][RMW]};
            dg7_reg  <= dg6_reg;
            sum8_reg <= SW'(sq7_reg[0]) + SW'(sq7_reg[1]) + SW'(sq7_reg[2]);
            rm8_reg  <= rm7_reg;
            sg8_reg  <= sg7_reg;
            dg8_reg  <= dg7_reg;
        end
    end

    assign sq_side_in = {dg8_reg, sg8_reg, rm8_reg[2], rm8_reg[1], rm8_reg[0]};

    tfn_isqrt #(
        .ROOT_W (QW),
        .SIDE_W (SQS)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[8]),
        .in_x      (sum8_reg),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign dv_mag[0] = sq_side[RMW-1:0];
    assign dv_mag[1] = sq_side[2*RMW-1:RMW];
    assign dv_mag[2] = sq_side[3*RMW-1:2*RMW];

    tfn_div #(
        .MAG_W  (RMW),
        .LEN_W  (QW),
        .FRAC_W (F),
        .SIDE_W (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_mag    (dv_mag),
        .in_len    (sq_root),
        .in_side   (sq_side[SQS-1:3*RMW]),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // clamp to 1.0 and restore the sign
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (dv_quot[c] > ((F + 1)'(1) << F))
                comp_next[c] = OW'(1) << F;
            else
                comp_next[c] = OW'(dv_quot[c]);
            if (dv_side[c])
                comp_next[c] = -comp_next[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dg_reg <= dv_side[3];
            if (dv_side[3])
            begin
                nx_reg <= '0;
                ny_reg <= OW'(1) << F;
                nz_reg <= '0;
            end
            else
            begin
                nx_reg <= comp_next[0];
                ny_reg <= comp_next[1];
                nz_reg <= comp_next[2];
            end
        end
    end

    assign nrm_valid  = out_valid_reg;
    assign norm_x     = nx_reg;
    assign norm_y     = ny_reg;
    assign norm_z     = nz_reg;
    assign degenerate = dg_reg;

    a_degen_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid && degenerate |->
            norm_x == '0 && norm_z == '0 && norm_y == (OW'(1) << F))
        else $error("degenerate result without fallback normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid |->
            norm_x <= (OW'(1) << F) && norm_x >= -(OW'(1) << F) &&
            norm_y <= (OW'(1) << F) && norm_y >= -(OW'(1) << F) &&
            norm_z <= (OW'(1) << F) && norm_z >= -(OW'(1) << F))
        else $error("normal component outside unit range");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid && !degenerate |-> norm_x != '0 || norm_y != '0 || norm_z != '0)
        else $error("non-degenerate normal is all zero");

    a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid && nrm_stall |=> nrm_valid && $stable(norm_x) && $stable(degenerate))
        else $error("stalled transaction changed");

endmodule
